### rtl/core/gdm_pkg.sv
// Shared types, constants and a helper function of the greedy descriptor matcher.
package gdm_pkg;

	localparam int DESCR_LEN       = 8;
	localparam int MAX_TARGETS_DEF = 64;
	localparam int ELEM_BITS_DEF   = 16;

	localparam int ID_W    = 16;
	localparam int COUNT_W = 8;
	localparam int REQ_W   = 2;
	localparam int DIST_W  = 40;
	localparam int SQ_IN_W = 20;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Request codes carried by req_type.
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_SQ      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT_DIFF = 1'd1;

	localparam logic [COUNT_W-1:0] MAX_COUNT_DIFF_RST = 8'd3;

	// Leaf count of the merge tree, a power of two of at least two.
	localparam int MRG_LEVELS = (DESCR_LEN > 2) ? $clog2(DESCR_LEN) : 1;
	localparam int MRG_PAD    = 1 << MRG_LEVELS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} gdm_state_t;

	// Sum of two distances, clipped at the largest representable distance.
	function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
	                                              input logic [DIST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
	endfunction

endpackage

### rtl/core/gdm_table.sv
// Target table: descriptor, point count, id and used mark of every loaded target.
module gdm_table
	import gdm_pkg::*;
#(
	parameter int MAX_TARGETS = MAX_TARGETS_DEF,
	parameter int ELEM_BITS   = ELEM_BITS_DEF,
	localparam int IDX_W      = $clog2(MAX_TARGETS)
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [IDX_W-1:0]                    wr_addr,
	input  logic [DESCR_LEN-1:0][ELEM_BITS-1:0] wr_descr,
	input  logic [COUNT_W-1:0]                  wr_count,
	input  logic [ID_W-1:0]                     wr_id,
	input  logic                                mark_wr_en,
	input  logic [IDX_W-1:0]                    mark_wr_addr,
	input  logic                                mark_wr_val,
	input  logic                                rd_en,
	input  logic [IDX_W-1:0]                    rd_addr,
	output logic [DESCR_LEN-1:0][ELEM_BITS-1:0] rd_descr_s1,
	output logic [COUNT_W-1:0]                  rd_count_s1,
	output logic [ID_W-1:0]                     rd_id_s1,
	output logic                                rd_used_s1
);

	localparam int ENT_W = DESCR_LEN * ELEM_BITS + COUNT_W + ID_W;

	logic [ENT_W-1:0] entry_mem [MAX_TARGETS];
	logic             mark_mem  [MAX_TARGETS];
	logic [ENT_W-1:0] entry_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= {wr_descr, wr_count, wr_id};
		end
		if (rd_en) begin
			entry_s1 <= entry_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mark_wr_en) begin
			mark_mem[mark_wr_addr] <= mark_wr_val;
		end
		if (rd_en) begin
			rd_used_s1 <= mark_mem[rd_addr];
		end
	end

	assign {rd_descr_s1, rd_count_s1, rd_id_s1} = entry_s1;

endmodule

### rtl/core/gdm_lane.sv
// One descriptor lane: element difference and its clipped square.
module gdm_lane
	import gdm_pkg::*;
#(
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  logic                        clk,
	input  logic signed [ELEM_BITS-1:0] a,
	input  logic signed [ELEM_BITS-1:0] b,
	output logic [DIST_W-1:0]           sq_s2
);

	localparam int MW = ELEM_BITS + 1;

	logic signed [MW-1:0] diff;
	logic [MW-1:0]        mag;
	logic [SQ_IN_W-1:0]   m20;
	logic                 big;

	assign diff = {a[ELEM_BITS-1], a} - {b[ELEM_BITS-1], b};
	assign mag  = diff[MW-1] ? (~diff + MW'(1)) : diff;

	// A magnitude of 2^20 or more squares past the distance range.
	generate
		if (MW > SQ_IN_W) begin : g_wide
			assign big = |mag[MW-1:SQ_IN_W];
			assign m20 = mag[SQ_IN_W-1:0];
		end else begin : g_narrow
			assign big = 1'b0;
			assign m20 = SQ_IN_W'(mag);
		end
	endgenerate

	always_ff @(posedge clk) begin
		sq_s2 <= big ? DIST_MAX : (DIST_W'(m20) * DIST_W'(m20));
	end

endmodule

### rtl/core/gdm_merge.sv
// Registered saturating adder tree that totals the lane squares.
module gdm_merge
	import gdm_pkg::*;
(
	input  logic                             clk,
	input  logic [DESCR_LEN-1:0][DIST_W-1:0] sq,
	output logic [DIST_W-1:0]                sum
);

	localparam int N_INT = MRG_PAD - 1;

	logic [DIST_W-1:0] leaf [MRG_PAD];
	logic [DIST_W-1:0] node [N_INT];

	// Heap layout: node i has children 2i+1 and 2i+2; indexes past the
	// internal nodes refer to leaves.
	genvar gi;
	generate
		for (gi = 0; gi < MRG_PAD; gi++) begin : g_leaf
			if (gi < DESCR_LEN) begin : g_used
				assign leaf[gi] = sq[gi];
			end else begin : g_pad
				assign leaf[gi] = '0;
			end
		end
		for (gi = 0; gi < N_INT; gi++) begin : g_node
			if (2 * gi + 1 >= N_INT) begin : g_bottom
				always_ff @(posedge clk) begin
					node[gi] <= sat_add(leaf[2 * gi + 1 - N_INT], leaf[2 * gi + 2 - N_INT]);
				end
			end else begin : g_inner
				always_ff @(posedge clk) begin
					node[gi] <= sat_add(node[2 * gi + 1], node[2 * gi + 2]);
				end
			end
		end
	endgenerate

	assign sum = node[0];

endmodule

### rtl/core/greedy_descriptor_matcher_core.sv
// Top level of the greedy descriptor matcher: control, lanes, merge and best-match tracking.
// A clear item opens a session, load items fill the target table one entry each, and a
// query item scans every loaded target in load order for the nearest unused target whose
// point count lies within max_count_diff of the reference count. Distance is the squared
// Euclidean distance of the descriptors, every square and sum clipped at 2^40-1; a tie
// keeps the earliest target. The best target is accepted, and marked used for the rest of
// the session, when its distance is strictly below thresh_sq. A clear or load item gives
// no result. A query reads the table at one entry per cycle; it runs through the table
// read, one lane stage, the merge tree levels, a drain check and a finish state that
// writes the used mark and loads the output register. A query on an empty table goes
// straight to the finish state. Items are taken one at a time; the output register lets
// loads and clears proceed while a result waits, and a later query holds in its finish
// state until that result is taken. Configuration writes are accepted in every cycle and
// belong in idle periods.
module greedy_descriptor_matcher_core
	import gdm_pkg::*;
#(
	parameter int MAX_TARGETS = MAX_TARGETS_DEF,
	parameter int ELEM_BITS   = ELEM_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [DIST_W-1:0]           cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [REQ_W-1:0]            req_type,
	input  logic [ID_W-1:0]             item_id,
	input  logic [COUNT_W-1:0]          point_count,
	input  logic signed [ELEM_BITS-1:0] descr_0,
	input  logic signed [ELEM_BITS-1:0] descr_1,
	input  logic signed [ELEM_BITS-1:0] descr_2,
	input  logic signed [ELEM_BITS-1:0] descr_3,
	input  logic signed [ELEM_BITS-1:0] descr_4,
	input  logic signed [ELEM_BITS-1:0] descr_5,
	input  logic signed [ELEM_BITS-1:0] descr_6,
	input  logic signed [ELEM_BITS-1:0] descr_7,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ID_W-1:0]             ref_id,
	output logic                        match_found,
	output logic [ID_W-1:0]             target_id,
	output logic [DIST_W-1:0]           best_dist_sq
);

	localparam int IDX_W = $clog2(MAX_TARGETS);
	localparam int CNT_W = $clog2(MAX_TARGETS + 1);

	// Sideband that follows one table entry through the lanes and the merge tree.
	typedef struct packed {
		logic             valid;
		logic             elig;
		logic [IDX_W-1:0] idx;
		logic [ID_W-1:0]  id;
	} tag_t;

	gdm_state_t state_q, state_d;

	// Configuration registers.
	logic [DIST_W-1:0]  thresh_sq_q;
	logic [COUNT_W-1:0] max_count_diff_q;

	// Session and query registers.
	logic [CNT_W-1:0]                    count_q;
	logic [IDX_W-1:0]                    scan_idx_q;
	logic [ID_W-1:0]                     qid_q;
	logic [COUNT_W-1:0]                  qcnt_q;
	logic [DESCR_LEN-1:0][ELEM_BITS-1:0] qdescr_q;
	logic [DESCR_LEN-1:0][ELEM_BITS-1:0] in_descr;

	// Best-match tracking.
	logic              have_q;
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [ID_W-1:0]   best_id_q;

	// Output register.
	logic              out_valid_q;
	logic [ID_W-1:0]   ref_id_q;
	logic              match_q;
	logic [ID_W-1:0]   target_id_q;
	logic [DIST_W-1:0] dist_q;

	// Table and pipeline.
	logic                                rd_en;
	logic                                rd_vld_s1;
	logic [IDX_W-1:0]                    rd_idx_s1;
	logic [DESCR_LEN-1:0][ELEM_BITS-1:0] t_descr_s1;
	logic [COUNT_W-1:0]                  t_count_s1;
	logic [ID_W-1:0]                     t_id_s1;
	logic                                t_used_s1;
	logic [COUNT_W-1:0]                  cnt_diff_s1;
	tag_t                                tag_s1;
	tag_t                                tag_q [MRG_LEVELS + 1];
	tag_t                                tag_last;
	logic [DESCR_LEN-1:0][DIST_W-1:0]    sq_s2;
	logic [DIST_W-1:0]                   dist_sum;

	logic in_acc, load_fire, clear_fire, query_fire, scan_last, pipe_busy;
	logic out_free, fin_fire, accept;
	logic mark_wr_en, mark_wr_val;
	logic [IDX_W-1:0] mark_wr_addr;

	assign in_descr[0] = descr_0;
	assign in_descr[1] = descr_1;
	assign in_descr[2] = descr_2;
	assign in_descr[3] = descr_3;
	assign in_descr[4] = descr_4;
	assign in_descr[5] = descr_5;
	assign in_descr[6] = descr_6;
	assign in_descr[7] = descr_7;

	assign cfg_ready = 1'b1;

	assign in_acc     = in_valid && !in_stall;
	assign clear_fire = in_acc && (req_type == REQ_CLEAR);
	assign query_fire = in_acc && (req_type == REQ_QUERY);
	// A load into a full table is dropped.
	assign load_fire  = in_acc && (req_type == REQ_LOAD) && (count_q < CNT_W'(MAX_TARGETS));

	assign scan_last = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = have_q && (best_q < thresh_sq_q);

	always_comb begin
		pipe_busy = rd_vld_s1;
		for (int k = 0; k <= MRG_LEVELS; k++) begin
			pipe_busy = pipe_busy | tag_q[k].valid;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_fire) begin
					state_d = (count_q == '0) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		fin_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_DRAIN: begin
				in_stall = 1'b1;
			end
			ST_FINISH: begin
				fin_fire = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// A load writes a clear used mark; an accepted query sets the mark of its winner.
	assign mark_wr_en   = load_fire || (fin_fire && accept);
	assign mark_wr_addr = load_fire ? count_q[IDX_W-1:0] : best_idx_q;
	assign mark_wr_val  = !load_fire;

	gdm_table #(
		.MAX_TARGETS (MAX_TARGETS),
		.ELEM_BITS   (ELEM_BITS)
	) u_table (
		.clk          (clk),
		.wr_en        (load_fire),
		.wr_addr      (count_q[IDX_W-1:0]),
		.wr_descr     (in_descr),
		.wr_count     (point_count),
		.wr_id        (item_id),
		.mark_wr_en   (mark_wr_en),
		.mark_wr_addr (mark_wr_addr),
		.mark_wr_val  (mark_wr_val),
		.rd_en        (rd_en),
		.rd_addr      (scan_idx_q),
		.rd_descr_s1  (t_descr_s1),
		.rd_count_s1  (t_count_s1),
		.rd_id_s1     (t_id_s1),
		.rd_used_s1   (t_used_s1)
	);

	// One lane per descriptor element, each comparing the query against the entry read.
	genvar gl;
	generate
		for (gl = 0; gl < DESCR_LEN; gl++) begin : g_lane
			gdm_lane #(
				.ELEM_BITS (ELEM_BITS)
			) u_lane (
				.clk   (clk),
				.a     (qdescr_q[gl]),
				.b     (t_descr_s1[gl]),
				.sq_s2 (sq_s2[gl])
			);
		end
	endgenerate

	gdm_merge u_merge (
		.clk (clk),
		.sq  (sq_s2),
		.sum (dist_sum)
	);

	// Point-count filter and used mark are settled while the squares are formed.
	assign cnt_diff_s1  = (t_count_s1 > qcnt_q) ? (t_count_s1 - qcnt_q) : (qcnt_q - t_count_s1);
	assign tag_s1.valid = rd_vld_s1;
	assign tag_s1.elig  = !t_used_s1 && (cnt_diff_s1 <= max_count_diff_q);
	assign tag_s1.idx   = rd_idx_s1;
	assign tag_s1.id    = t_id_s1;
	assign tag_last     = tag_q[MRG_LEVELS];

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			thresh_sq_q      <= '0;
			max_count_diff_q <= MAX_COUNT_DIFF_RST;
			count_q          <= '0;
			scan_idx_q       <= '0;
			rd_vld_s1        <= 1'b0;
			have_q           <= 1'b0;
			best_q           <= DIST_MAX;
			out_valid_q      <= 1'b0;
			for (int k = 0; k <= MRG_LEVELS; k++) begin
				tag_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESH_SQ:      thresh_sq_q      <= cfg_data;
					REG_MAX_COUNT_DIFF: max_count_diff_q <= cfg_data[COUNT_W-1:0];
					default:            thresh_sq_q      <= thresh_sq_q;
				endcase
			end

			if (clear_fire) begin
				count_q <= '0;
			end else if (load_fire) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (query_fire) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
			rd_vld_s1 <= rd_en;

			tag_q[0] <= tag_s1;
			for (int k = 1; k <= MRG_LEVELS; k++) begin
				tag_q[k] <= tag_q[k-1];
			end

			// Strict compare keeps the earliest of equal distances.
			if (query_fire) begin
				have_q <= 1'b0;
				best_q <= DIST_MAX;
			end else if (tag_last.valid && tag_last.elig && (!have_q || dist_sum < best_q)) begin
				have_q <= 1'b1;
				best_q <= dist_sum;
			end

			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (query_fire) begin
			qid_q    <= item_id;
			qcnt_q   <= point_count;
			qdescr_q <= in_descr;
		end
		rd_idx_s1 <= scan_idx_q;
		if (tag_last.valid && tag_last.elig && (!have_q || dist_sum < best_q)) begin
			best_idx_q <= tag_last.idx;
			best_id_q  <= tag_last.id;
		end
		if (fin_fire) begin
			ref_id_q    <= qid_q;
			match_q     <= accept;
			target_id_q <= accept ? best_id_q : '0;
			dist_q      <= best_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign ref_id       = ref_id_q;
	assign match_found  = match_q;
	assign target_id    = target_id_q;
	assign best_dist_sq = dist_q;

endmodule
